// ===== hw/rtl/tsq_pkg.sv =====
`default_nettype none

package tsq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int ACT_W         = 2;
    localparam int STAT_W        = 2;
    localparam int CAP_W         = 5;
    localparam int OP_W          = 2;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // Action codes on the input channel.
    localparam logic [ACT_W-1:0] ACT_ENQ   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FRONT = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Operation codes handed from the front end to the back end.
    localparam logic [OP_W-1:0] OP_NOP   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENQ   = 2'd1;
    localparam logic [OP_W-1:0] OP_DEQ   = 2'd2;
    localparam logic [OP_W-1:0] OP_FRONT = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] data;
    } item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsq_fifo.sv =====
`default_nettype none

module tsq_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_valid,
    output logic                 wr_ready,
    input  wire tsq_pkg::item_t  wr_item,
    output logic                 rd_valid,
    input  wire logic            rd_pop,
    output tsq_pkg::item_t       rd_item
);

    tsq_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tsq_front.sv =====
`default_nettype none

module tsq_front (
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [tsq_pkg::ACT_W-1:0]   action,
    input  wire logic [tsq_pkg::DATA_W-1:0]  value,
    output logic                             q_push,
    input  wire logic                        q_ready,
    output tsq_pkg::item_t                   q_item
);

    assign in_stall = !q_ready;
    assign q_push   = in_valid;

    // The value only matters for an enqueue, so it is dropped for the rest.
    always_comb
    begin
        q_item.data = '0;
        case (action)
            tsq_pkg::ACT_ENQ:
            begin
                q_item.op   = tsq_pkg::OP_ENQ;
                q_item.data = value;
            end
            tsq_pkg::ACT_DEQ:   q_item.op = tsq_pkg::OP_DEQ;
            tsq_pkg::ACT_FRONT: q_item.op = tsq_pkg::OP_FRONT;
            default:            q_item.op = tsq_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tsq_back.sv =====
`default_nettype none

module tsq_back #(
    parameter int DEPTH = tsq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [tsq_pkg::CAP_W-1:0]    capacity,
    input  wire logic                         q_valid,
    input  wire tsq_pkg::item_t               q_item,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [tsq_pkg::STAT_W-1:0]        status,
    output logic signed [tsq_pkg::DATA_W-1:0] value_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > tsq_pkg::CAP_W) ? CW : tsq_pkg::CAP_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_XFER = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [tsq_pkg::DATA_W-1:0] in_mem  [DEPTH];
    logic [tsq_pkg::DATA_W-1:0] out_mem [DEPTH];

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [CW-1:0] in_count_reg;
    logic [CW-1:0] in_count_next;
    logic [CW-1:0] out_count_reg;
    logic [CW-1:0] out_count_next;
    logic          rd_pend_reg;
    logic          rd_pend_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [tsq_pkg::STAT_W-1:0]  status_reg;
    logic [tsq_pkg::STAT_W-1:0]  status_next;
    logic [tsq_pkg::DATA_W-1:0]  value_reg;
    logic [tsq_pkg::DATA_W-1:0]  value_next;

    logic                        in_wr_en;
    logic                        in_rd_en;
    logic [AW-1:0]               in_rd_addr;
    logic [tsq_pkg::DATA_W-1:0]  in_rdata_reg;
    logic                        out_wr_en;
    logic                        out_rd_en;
    logic [AW-1:0]               out_rd_addr;
    logic [tsq_pkg::DATA_W-1:0]  out_rdata_reg;

    logic [CW-1:0] in_m1;
    logic [CW-1:0] out_m1;
    logic          out_take;
    logic          slot_free;
    logic          in_full;
    logic          both_empty;

    assign in_m1       = in_count_reg - CW'(1);
    assign out_m1      = out_count_reg - CW'(1);
    assign in_rd_addr  = in_m1[AW-1:0];
    assign out_rd_addr = out_m1[AW-1:0];
    assign out_take    = out_valid_reg && !out_stall;
    assign slot_free   = !out_valid_reg || out_take;
    assign in_full     = (in_count_reg == CW'(DEPTH))
                      || (MW'(in_count_reg) >= MW'(capacity));
    assign both_empty  = (in_count_reg == '0) && (out_count_reg == '0);

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = value_reg;

    always_comb
    begin
        state_next     = state_reg;
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        rd_pend_next   = 1'b0;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        q_pop          = 1'b0;
        in_wr_en       = 1'b0;
        in_rd_en       = 1'b0;
        out_wr_en      = 1'b0;
        out_rd_en      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    case (q_item.op)
                        tsq_pkg::OP_ENQ:
                        begin
                            q_pop          = 1'b1;
                            out_valid_next = 1'b1;
                            value_next     = '0;
                            if (in_full)
                            begin
                                status_next = tsq_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_next   = tsq_pkg::ST_DONE;
                                in_wr_en      = 1'b1;
                                in_count_next = in_count_reg + CW'(1);
                            end
                        end
                        tsq_pkg::OP_DEQ, tsq_pkg::OP_FRONT:
                        begin
                            if (both_empty)
                            begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                status_next    = tsq_pkg::ST_EMPTY;
                                value_next     = '0;
                            end
                            else if (out_count_reg == '0)
                            begin
                                // Refill first; the item stays queued and is
                                // taken again once the transfer is over.
                                state_next = S_XFER;
                            end
                            else
                            begin
                                q_pop      = 1'b1;
                                out_rd_en  = 1'b1;
                                state_next = S_READ;
                                if (q_item.op == tsq_pkg::OP_DEQ)
                                begin
                                    out_count_next = out_m1;
                                end
                            end
                        end
                        default:
                        begin
                            q_pop          = 1'b1;
                            out_valid_next = 1'b1;
                            status_next    = tsq_pkg::ST_DONE;
                            value_next     = '0;
                        end
                    endcase
                end
            end
            S_XFER:
            begin
                // One entry leaves the input stack per cycle; its read data is registered
                // and lands on the output stack in the next cycle.
                if (in_count_reg != '0)
                begin
                    in_rd_en      = 1'b1;
                    in_count_next = in_m1;
                    rd_pend_next  = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
                if (rd_pend_reg)
                begin
                    out_wr_en      = 1'b1;
                    out_count_next = out_count_reg + CW'(1);
                end
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                status_next    = tsq_pkg::ST_DONE;
                value_next     = out_rdata_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_wr_en)
        begin
            in_mem[in_count_reg[AW-1:0]] <= q_item.data;
        end
        if (in_rd_en)
        begin
            in_rdata_reg <= in_mem[in_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_wr_en)
        begin
            out_mem[out_count_reg[AW-1:0]] <= in_rdata_reg;
        end
        if (out_rd_en)
        begin
            out_rdata_reg <= out_mem[out_rd_addr];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_count_reg <= CW'(DEPTH)) && (in_count_reg <= CW'(DEPTH)))
        else $error("stack count beyond depth");

    a_xfer_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_XFER) && !rd_pend_reg |-> (out_count_reg == '0))
        else $error("transfer started on a non-empty output stack");

    a_xfer_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_XFER) |-> (in_count_reg != '0) || rd_pend_reg)
        else $error("transfer state with nothing to move");

    a_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !out_valid_reg)
        else $error("read result would overwrite a pending beat");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE) && q_valid && slot_free)
        else $error("queue popped outside idle");

endmodule

`default_nettype wire

// ===== hw/rtl/two_stack_queue.sv =====
// An input beat passes through the two-entry item FIFO; the back end then registers the result
// of an enqueue or refused/empty request, while a dequeue or front from a filled output stack
// first reads the output-stack memory and takes its value in S_READ; one that finds it empty
// first moves the n input-stack entries over, one per cycle through the input-stack read port.
// One enqueue per cycle unless out_stall holds a result; a dequeue or front waits for S_READ.
// Reset clears both stack counts, the item queue and the result valid, and sets capacity to 16.
`default_nettype none

module two_stack_queue #(
    parameter int DEPTH = tsq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tsq_pkg::CAP_W-1:0]    capacity,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [tsq_pkg::ACT_W-1:0]    action,
    input  wire logic signed [tsq_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [tsq_pkg::STAT_W-1:0]        status,
    output logic signed [tsq_pkg::DATA_W-1:0] value_out
);

    logic [tsq_pkg::CAP_W-1:0] capacity_reg;
    logic                      f_push;
    logic                      f_ready;
    tsq_pkg::item_t            f_item;
    logic                      b_valid;
    logic                      b_pop;
    tsq_pkg::item_t            b_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= tsq_pkg::CAPACITY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= capacity;
        end
    end

    tsq_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .value    (value),
        .q_push   (f_push),
        .q_ready  (f_ready),
        .q_item   (f_item)
    );

    tsq_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_push),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (b_valid),
        .rd_pop   (b_pop),
        .rd_item  (b_item)
    );

    tsq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .q_valid   (b_valid),
        .q_item    (b_item),
        .q_pop     (b_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .value_out (value_out)
    );

endmodule

`default_nettype wire
